[hdl/tbie_pkg.sv]
// Package for the three-band isolator: payload types, fixed widths, register
// indexes, sequencer phase and step codes, accumulator commands.
// No dependencies.
package tbie_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int LEVEL_W      = 16;
    localparam int DATA_W       = 32;
    localparam int OP_A_W       = 34;
    localparam int PROD_W       = OP_A_W + DATA_W;
    localparam int ACC_W        = PROD_W + 2;
    localparam int GAIN_FRAC    = 30;
    localparam int CFG_IDX_W    = 3;
    localparam int HIST_DEPTH   = 64;
    localparam int HIST_AW      = 6;
    localparam int PH_W         = 2;
    localparam int STEP_W       = 3;
    localparam int STAGE_W      = 3;
    localparam int NUM_BANDS    = 3;

    localparam logic signed [17:0] LEVEL_ONE = 18'sd32768;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LP_A0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_HP_A0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_FB1    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_FB2    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_LP_A0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_HP_A0 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_FB1   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_FB2   = 3'd7;

    // Sequencer phases
    localparam logic [PH_W-1:0] PH_IDLE  = 2'd0;
    localparam logic [PH_W-1:0] PH_GAIN  = 2'd1;
    localparam logic [PH_W-1:0] PH_STAGE = 2'd2;
    localparam logic [PH_W-1:0] PH_MIX   = 2'd3;

    // Steps inside one biquad stage
    localparam logic [STEP_W-1:0] STEP_X     = 3'd0;
    localparam logic [STEP_W-1:0] STEP_H0    = 3'd1;
    localparam logic [STEP_W-1:0] STEP_H1    = 3'd2;
    localparam logic [STEP_W-1:0] STEP_Y1    = 3'd3;
    localparam logic [STEP_W-1:0] STEP_Y2    = 3'd4;
    localparam logic [STEP_W-1:0] STEP_DRAIN = 3'd5;
    localparam logic [STEP_W-1:0] STEP_ROUND = 3'd6;

    localparam logic [STEP_W-1:0]  STEP_GAIN_LAST = 3'd3;
    localparam logic [STEP_W-1:0]  STEP_MIX_LAST  = 3'd4;
    localparam logic [STAGE_W-1:0] STAGE_LAST     = 3'd7;

    // History entry offsets within a stage
    localparam logic [1:0] HK_X1 = 2'd0;
    localparam logic [1:0] HK_X2 = 2'd1;
    localparam logic [1:0] HK_Y1 = 2'd2;
    localparam logic [1:0] HK_Y2 = 2'd3;

    // Band slots
    localparam logic [1:0] BAND_LOW  = 2'd0;
    localparam logic [1:0] BAND_MID  = 2'd1;
    localparam logic [1:0] BAND_HIGH = 2'd2;

    // Accumulator commands
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] left_in;
        logic signed [SAMPLE_WIDTH-1:0] right_in;
        logic signed [LEVEL_W-1:0]      low_level;
        logic signed [LEVEL_W-1:0]      mid_level;
        logic signed [LEVEL_W-1:0]      high_level;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] left_out;
        logic signed [SAMPLE_WIDTH-1:0] right_out;
    } out_item_t;

    typedef struct packed {
        logic [PH_W-1:0]    phase;
        logic               ch;
        logic [STAGE_W-1:0] stage;
        logic [STEP_W-1:0]  step;
        logic [1:0]         acc_op;
    } seq_ctrl_t;

endpackage

[hdl/tbie_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tbie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/tbie_mac.sv]
// Shared multiply-accumulate unit: registered 34x32 product, wide accumulator,
// round-half-up and saturation for biquad outputs and for the band mix.
// Depends on tbie_pkg.
module tbie_mac #(
    parameter int FRAC_BITS = 30
) (
    input  logic                                    clk,
    input  logic [1:0]                              acc_op,
    input  logic signed [tbie_pkg::OP_A_W-1:0]      op_a,
    input  logic signed [tbie_pkg::DATA_W-1:0]      op_b,
    output logic signed [tbie_pkg::PROD_W-1:0]      prod,
    output logic signed [tbie_pkg::DATA_W-1:0]      stage_y,
    output logic signed [tbie_pkg::SAMPLE_WIDTH-1:0] mix_y
);
    import tbie_pkg::*;

    localparam logic signed [ACC_W-1:0] ONE_ACC = {{(ACC_W-1){1'b0}}, 1'b1};
    localparam logic signed [ACC_W-1:0] STAGE_HALF = ONE_ACC <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] MIX_HALF   = ONE_ACC <<< (GAIN_FRAC - 1);
    localparam logic signed [ACC_W-1:0] Y_MAX =
        {{(ACC_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] Y_MIN = ~Y_MAX;
    localparam logic signed [ACC_W-1:0] S_MAX =
        {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] S_MIN = ~S_MAX;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  stage_q;
    logic signed [ACC_W-1:0]  mix_q;

    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    always_comb
    begin
        case (acc_op)
            ACC_LOAD: acc_next = prod_ext;
            ACC_ADD:  acc_next = acc_reg + prod_ext;
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
        acc_reg  <= acc_next;
    end

    assign prod    = prod_reg;
    assign stage_q = (acc_reg + STAGE_HALF) >>> FRAC_BITS;
    assign mix_q   = (acc_reg + MIX_HALF) >>> GAIN_FRAC;

    always_comb
    begin
        if (stage_q > Y_MAX)
        begin
            stage_y = Y_MAX[DATA_W-1:0];
        end
        else if (stage_q < Y_MIN)
        begin
            stage_y = Y_MIN[DATA_W-1:0];
        end
        else
        begin
            stage_y = stage_q[DATA_W-1:0];
        end

        if (mix_q > S_MAX)
        begin
            mix_y = S_MAX[SAMPLE_WIDTH-1:0];
        end
        else if (mix_q < S_MIN)
        begin
            mix_y = S_MIN[SAMPLE_WIDTH-1:0];
        end
        else
        begin
            mix_y = mix_q[SAMPLE_WIDTH-1:0];
        end
    end

endmodule

[hdl/tbie_seq.sv]
// Sequencer for the isolator: steps through gain setup, eight biquad stages
// per channel and the band mix, and drives the accumulator commands.
// Depends on tbie_pkg.
module tbie_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 out_free,
    output tbie_pkg::seq_ctrl_t  ctrl
);
    import tbie_pkg::*;

    logic [PH_W-1:0]    phase_reg, phase_next;
    logic               ch_reg, ch_next;
    logic [STAGE_W-1:0] stage_reg, stage_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [1:0]         acc_op;

    always_comb
    begin
        phase_next = phase_reg;
        ch_next    = ch_reg;
        stage_next = stage_reg;
        step_next  = step_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    phase_next = PH_GAIN;
                    ch_next    = 1'b0;
                    step_next  = '0;
                end
            end
            PH_GAIN:
            begin
                if (step_reg == STEP_GAIN_LAST)
                begin
                    phase_next = PH_STAGE;
                    stage_next = '0;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            PH_STAGE:
            begin
                if (step_reg == STEP_ROUND)
                begin
                    step_next = '0;
                    if (stage_reg == STAGE_LAST)
                    begin
                        phase_next = PH_MIX;
                    end
                    else
                    begin
                        stage_next = stage_reg + 1'b1;
                    end
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            PH_MIX:
            begin
                if (step_reg != STEP_MIX_LAST)
                begin
                    step_next = step_reg + 1'b1;
                end
                else if (!ch_reg)
                begin
                    // advance to the right channel
                    ch_next    = 1'b1;
                    phase_next = PH_STAGE;
                    stage_next = '0;
                    step_next  = '0;
                end
                else if (out_free)
                begin
                    phase_next = PH_IDLE;
                    ch_next    = 1'b0;
                    step_next  = '0;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            ch_reg    <= 1'b0;
            stage_reg <= '0;
            step_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            ch_reg    <= ch_next;
            stage_reg <= stage_next;
            step_reg  <= step_next;
        end
    end

    // products land in the cycle after issue; load on the first, add the rest
    always_comb
    begin
        acc_op = ACC_HOLD;
        case (phase_reg)
            PH_STAGE:
            begin
                if (step_reg == STEP_H0)
                begin
                    acc_op = ACC_LOAD;
                end
                else if (step_reg inside {STEP_H1, STEP_Y1, STEP_Y2, STEP_DRAIN})
                begin
                    acc_op = ACC_ADD;
                end
            end
            PH_MIX:
            begin
                if (step_reg == 3'd1)
                begin
                    acc_op = ACC_LOAD;
                end
                else if (step_reg inside {3'd2, 3'd3})
                begin
                    acc_op = ACC_ADD;
                end
            end
            default:
            begin
                acc_op = ACC_HOLD;
            end
        endcase
    end

    assign ctrl.phase  = phase_reg;
    assign ctrl.ch     = ch_reg;
    assign ctrl.stage  = stage_reg;
    assign ctrl.step   = step_reg;
    assign ctrl.acc_op = acc_op;

    a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_STAGE && step_reg == STEP_ROUND && stage_reg != STAGE_LAST)
        |=> (stage_reg == $past(stage_reg) + 1'b1 && step_reg == STEP_X))
        else $error("stage did not advance after rounding step");

    a_mix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_MIX && step_reg == STEP_MIX_LAST && ch_reg && !out_free)
        |=> (phase_reg == PH_MIX && step_reg == STEP_MIX_LAST))
        else $error("final mix step left while result register busy");

endmodule

[hdl/three_band_isolator_eq.sv]
// Top level of the stereo three-band isolator: configuration registers,
// operand selection, filter history RAM and result register.
// Depends on tbie_pkg, tbie_ram, tbie_mac, tbie_seq.
//
// Usage:
//   item channel: item_valid/item_ready carry one stereo sample pair and three
//   band levels. item_ready is high only while the block is idle.
//   result channel: result_valid/result_ready carry the equalized pair, held
//   in an output register until taken.
//   cfg channel: cfg_valid/cfg_ready write coefficient register cfg_index with
//   cfg_data; cfg_ready is always high. Indexes beyond the list are dropped.
// Sequence: after an accepted request, gain setup on the shared multiplier,
//   then per channel 8 biquad stages (5 products, pipeline drain, rounding)
//   and a band mix; result_valid rises at the end of the second channel's mix.
// Occupancy: one item at a time; all 89 products of an item go in turn through
//   the single 34x32 multiply-accumulate unit, and item_ready stays low until done.
// Reset: coefficients clear to zero and all 64 history entries read as zero
//   (per-entry valid bits) with no clearing pass.
// Stall: if a previous result is still held at the end of an item, the block
//   waits in its final mix step until result_ready frees the register.
module three_band_isolator_eq #(
    parameter int COEF_FRAC_BITS = 30
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  tbie_pkg::in_item_t                item,
    output logic                              result_valid,
    input  logic                              result_ready,
    output tbie_pkg::out_item_t               result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tbie_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tbie_pkg::DATA_W-1:0]       cfg_data
);
    import tbie_pkg::*;

    seq_ctrl_t ctrl;

    logic signed [DATA_W-1:0] low_lp_a0_reg, low_hp_a0_reg, low_fb1_reg, low_fb2_reg;
    logic signed [DATA_W-1:0] high_lp_a0_reg, high_hp_a0_reg, high_fb1_reg, high_fb2_reg;

    in_item_t                       item_reg;
    logic signed [OP_A_W-1:0]       gain_reg [NUM_BANDS];
    logic signed [DATA_W-1:0]       band_reg [NUM_BANDS];
    logic signed [DATA_W-1:0]       x_reg;
    logic signed [DATA_W-1:0]       h0_reg;
    logic signed [DATA_W-1:0]       h2_reg;
    logic signed [SAMPLE_WIDTH-1:0] left_reg;
    out_item_t                      result_reg;
    logic                           result_valid_reg;
    logic [HIST_DEPTH-1:0]          hist_vld_reg;
    logic                           rd_vld_reg;

    logic                           accept;
    logic                           out_free;
    logic signed [OP_A_W-1:0]       op_a;
    logic signed [DATA_W-1:0]       op_b;
    logic signed [PROD_W-1:0]       prod;
    logic signed [DATA_W-1:0]       stage_y;
    logic signed [SAMPLE_WIDTH-1:0] mix_y;
    logic [1:0]                     acc_op;

    logic signed [SAMPLE_WIDTH-1:0] sample_sel;
    logic signed [DATA_W-1:0]       sample_ch;
    logic signed [DATA_W-1:0]       stage_x;
    logic signed [DATA_W-1:0]       hist;
    logic [DATA_W-1:0]              hist_rdata;
    logic signed [DATA_W-1:0]       a0_sel, fb1_sel, fb2_sel;
    logic                           hp_sel;
    logic signed [OP_A_W-1:0]       a0_ext, a1_ext, fb1_ext, fb2_ext;
    logic signed [LEVEL_W-1:0]      lvl;
    logic signed [17:0]             lvl_ext, t_neg, t_pos;
    logic [1:0]                     band_idx;

    logic                           hist_we;
    logic [1:0]                     wr_k;
    logic [HIST_AW-1:0]             hist_waddr;
    logic [HIST_AW-1:0]             hist_raddr;
    logic signed [DATA_W-1:0]       hist_wdata;

    assign accept    = item_valid && item_ready;
    assign out_free  = !result_valid_reg || result_ready;
    assign item_ready = (ctrl.phase == PH_IDLE);
    assign cfg_ready = 1'b1;

    tbie_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    assign acc_op = ctrl.acc_op;

    tbie_mac #(
        .FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .clk     (clk),
        .acc_op  (acc_op),
        .op_a    (op_a),
        .op_b    (op_b),
        .prod    (prod),
        .stage_y (stage_y),
        .mix_y   (mix_y)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_lp_a0_reg  <= '0;
            low_hp_a0_reg  <= '0;
            low_fb1_reg    <= '0;
            low_fb2_reg    <= '0;
            high_lp_a0_reg <= '0;
            high_hp_a0_reg <= '0;
            high_fb1_reg   <= '0;
            high_fb2_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LOW_LP_A0:  low_lp_a0_reg  <= cfg_data;
                REG_LOW_HP_A0:  low_hp_a0_reg  <= cfg_data;
                REG_LOW_FB1:    low_fb1_reg    <= cfg_data;
                REG_LOW_FB2:    low_fb2_reg    <= cfg_data;
                REG_HIGH_LP_A0: high_lp_a0_reg <= cfg_data;
                REG_HIGH_HP_A0: high_hp_a0_reg <= cfg_data;
                REG_HIGH_FB1:   high_fb1_reg   <= cfg_data;
                REG_HIGH_FB2:   high_fb2_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Stage coefficient selection: low LP, high HP, low HP, high LP pairs
    always_comb
    begin
        case (ctrl.stage[2:1])
            2'd0:
            begin
                a0_sel = low_lp_a0_reg;  hp_sel = 1'b0;
                fb1_sel = low_fb1_reg;   fb2_sel = low_fb2_reg;
            end
            2'd1:
            begin
                a0_sel = high_hp_a0_reg; hp_sel = 1'b1;
                fb1_sel = high_fb1_reg;  fb2_sel = high_fb2_reg;
            end
            2'd2:
            begin
                a0_sel = low_hp_a0_reg;  hp_sel = 1'b1;
                fb1_sel = low_fb1_reg;   fb2_sel = low_fb2_reg;
            end
            default:
            begin
                a0_sel = high_lp_a0_reg; hp_sel = 1'b0;
                fb1_sel = high_fb1_reg;  fb2_sel = high_fb2_reg;
            end
        endcase
    end

    assign a0_ext  = {{(OP_A_W-DATA_W){a0_sel[DATA_W-1]}}, a0_sel};
    assign fb1_ext = {{(OP_A_W-DATA_W){fb1_sel[DATA_W-1]}}, fb1_sel};
    assign fb2_ext = {{(OP_A_W-DATA_W){fb2_sel[DATA_W-1]}}, fb2_sel};
    assign a1_ext  = hp_sel ? -(a0_ext <<< 1) : (a0_ext <<< 1);

    assign sample_sel = ctrl.ch ? item_reg.right_in : item_reg.left_in;
    assign sample_ch  = {{(DATA_W-SAMPLE_WIDTH){sample_sel[SAMPLE_WIDTH-1]}}, sample_sel};
    // first stage of each band chain takes the raw sample
    assign stage_x = (ctrl.stage inside {3'd0, 3'd2, 3'd4}) ? sample_ch : x_reg;
    assign hist    = rd_vld_reg ? $signed(hist_rdata) : '0;

    // Level to gain: (1+p)^2 below zero, (1+3p) at or above, Q.30
    always_comb
    begin
        case (ctrl.step[1:0])
            2'd0:    lvl = item_reg.low_level;
            2'd1:    lvl = item_reg.mid_level;
            default: lvl = item_reg.high_level;
        endcase
    end

    assign lvl_ext = {{(18-LEVEL_W){lvl[LEVEL_W-1]}}, lvl};
    assign t_neg   = LEVEL_ONE + lvl_ext;
    assign t_pos   = LEVEL_ONE + lvl_ext + (lvl_ext <<< 1);
    assign band_idx = ctrl.step[1:0];

    // Operand selection for the shared multiplier
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (ctrl.phase)
            PH_GAIN:
            begin
                if (lvl[LEVEL_W-1])
                begin
                    op_a = {{(OP_A_W-18){t_neg[17]}}, t_neg};
                    op_b = {{(DATA_W-18){t_neg[17]}}, t_neg};
                end
                else
                begin
                    op_a = {{(OP_A_W-18){t_pos[17]}}, t_pos};
                    op_b = {{(DATA_W-18){1'b0}}, LEVEL_ONE};
                end
            end
            PH_STAGE:
            begin
                case (ctrl.step)
                    STEP_X:  begin op_a = a0_ext;   op_b = stage_x; end
                    STEP_H0: begin op_a = a1_ext;   op_b = hist;    end
                    STEP_H1: begin op_a = a0_ext;   op_b = hist;    end
                    STEP_Y1: begin op_a = -fb1_ext; op_b = hist;    end
                    STEP_Y2: begin op_a = -fb2_ext; op_b = hist;    end
                    default: begin op_a = '0;       op_b = '0;      end
                endcase
            end
            PH_MIX:
            begin
                if (ctrl.step < 3'd3)
                begin
                    op_a = gain_reg[band_idx];
                    op_b = band_reg[band_idx];
                end
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // History RAM access: read x1, x2, y1, y2 in order; shift entries behind the reads
    assign hist_raddr = {ctrl.ch, ctrl.stage, ctrl.step[1:0]};

    always_comb
    begin
        hist_we    = 1'b0;
        wr_k       = HK_X1;
        hist_wdata = stage_x;
        if (ctrl.phase == PH_STAGE)
        begin
            case (ctrl.step)
                STEP_H0:    begin hist_we = 1'b1; wr_k = HK_X1; hist_wdata = stage_x; end
                STEP_H1:    begin hist_we = 1'b1; wr_k = HK_X2; hist_wdata = h0_reg;  end
                STEP_Y2:    begin hist_we = 1'b1; wr_k = HK_Y2; hist_wdata = h2_reg;  end
                STEP_ROUND: begin hist_we = 1'b1; wr_k = HK_Y1; hist_wdata = stage_y; end
                default:    begin hist_we = 1'b0; wr_k = HK_X1; hist_wdata = stage_x; end
            endcase
        end
    end

    assign hist_waddr = {ctrl.ch, ctrl.stage, wr_k};

    tbie_ram #(
        .WIDTH (DATA_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .clk     (clk),
        .wr_en   (hist_we),
        .wr_addr (hist_waddr),
        .wr_data (hist_wdata),
        .rd_addr (hist_raddr),
        .rd_data (hist_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= hist_vld_reg[hist_raddr];
            if (hist_we)
            begin
                hist_vld_reg[hist_waddr] <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end

        if (ctrl.phase == PH_GAIN && ctrl.step != 3'd0)
        begin
            gain_reg[ctrl.step[1:0] - 2'd1] <= prod[OP_A_W-1:0];
        end

        if (ctrl.phase == PH_STAGE)
        begin
            if (ctrl.step == STEP_H0)
            begin
                h0_reg <= hist;
            end
            if (ctrl.step == STEP_Y1)
            begin
                h2_reg <= hist;
            end
            if (ctrl.step == STEP_ROUND)
            begin
                x_reg <= stage_y;
                case (ctrl.stage)
                    3'd1:    band_reg[BAND_LOW]  <= stage_y;
                    3'd3:    band_reg[BAND_HIGH] <= stage_y;
                    3'd7:    band_reg[BAND_MID]  <= stage_y;
                    default: ;
                endcase
            end
        end

        if (ctrl.phase == PH_MIX && ctrl.step == STEP_MIX_LAST)
        begin
            if (!ctrl.ch)
            begin
                left_reg <= mix_y;
            end
            else if (out_free)
            begin
                result_reg.left_out  <= left_reg;
                result_reg.right_out <= mix_y;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (ctrl.phase == PH_MIX && ctrl.step == STEP_MIX_LAST && ctrl.ch && out_free)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_result_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> (ctrl.phase == PH_IDLE))
        else $error("result raised outside end of item");

    a_hist_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (hist_we && ctrl.step != STEP_ROUND) |-> (hist_waddr != hist_raddr))
        else $error("history write hits the entry being read");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (ctrl.phase == PH_GAIN && ctrl.step == 3'd0))
        else $error("accepted request did not start gain setup");

endmodule
